// ===== rtl/core/cdmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdmr_pkg
// shared widths, types and the 3x5 digit font for the clock matrix renderer
// ----------------------------------------------------------------------------
package cdmr_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int WORD_W   = 32;
    localparam int COLS     = 12;
    localparam int ROWS     = 8;
    localparam int PIXELS   = COLS * ROWS;
    localparam int GLYPH_H  = 5;
    localparam int GLYPH_W  = 3;

    // glyph origins (column, row)
    localparam int HOUR_TENS_X   = 0;
    localparam int HOUR_UNITS_X  = 3;
    localparam int HOUR_Y        = 1;
    localparam int MIN_TENS_X    = 6;
    localparam int MIN_UNITS_X   = 9;
    localparam int MIN_Y         = 2;
    localparam int SEC_TENS_X    = 6;
    localparam int SEC_TENS_Y    = 0;
    localparam int SEC_UNITS_Y   = 7;

    typedef logic [PIXELS-1:0] frame_t;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
    } dec_t;

    typedef struct packed {
        logic hour_tens_on;
        dec_t hour;
        dec_t minute;
        dec_t second;
    } digits_t;

    // split a value below 64 into decimal tens and units
    function automatic dec_t dec_split(input logic [5:0] v);
        dec_t       d;
        logic [5:0] base;
        priority if (v >= 6'd60) begin d.tens = 3'd6; base = 6'd60; end
        else if (v >= 6'd50)     begin d.tens = 3'd5; base = 6'd50; end
        else if (v >= 6'd40)     begin d.tens = 3'd4; base = 6'd40; end
        else if (v >= 6'd30)     begin d.tens = 3'd3; base = 6'd30; end
        else if (v >= 6'd20)     begin d.tens = 3'd2; base = 6'd20; end
        else if (v >= 6'd10)     begin d.tens = 3'd1; base = 6'd10; end
        else                     begin d.tens = 3'd0; base = 6'd0;  end
        d.units = 4'(v - base);
        return d;
    endfunction

    // one font row, bit 2 is the leftmost column, row 0 on top
    function automatic logic [2:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
        logic [14:0] pat;
        logic [3:0]  sh;
        unique case (digit)
            4'd0:    pat = 15'b111_101_101_101_111;
            4'd1:    pat = 15'b001_001_001_001_001;
            4'd2:    pat = 15'b111_001_111_100_111;
            4'd3:    pat = 15'b111_001_111_001_111;
            4'd4:    pat = 15'b101_101_111_001_001;
            4'd5:    pat = 15'b111_100_111_001_111;
            4'd6:    pat = 15'b111_100_111_101_111;
            4'd7:    pat = 15'b111_001_001_001_001;
            4'd8:    pat = 15'b111_101_111_101_111;
            4'd9:    pat = 15'b111_101_111_001_111;
            default: pat = '0;
        endcase
        sh = 4'(12 - 3 * int'(row));
        return 3'(pat >> sh);
    endfunction

endpackage

// ===== rtl/core/cdmr_time_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdmr_time_if
// valid/ready channel carrying one time of day item
// ----------------------------------------------------------------------------
interface cdmr_time_if;
    logic                          valid;
    logic                          ready;
    logic [cdmr_pkg::HOUR_W-1:0]   hour_value;
    logic [cdmr_pkg::MINUTE_W-1:0] minute_value;
    logic [cdmr_pkg::SECOND_W-1:0] second_value;

    modport source (output valid, output hour_value, output minute_value,
                    output second_value, input ready);
    modport sink   (input valid, input hour_value, input minute_value,
                    input second_value, output ready);
endinterface

// ===== rtl/core/cdmr_frame_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdmr_frame_if
// valid/ready channel carrying one rendered frame as three words
// ----------------------------------------------------------------------------
interface cdmr_frame_if;
    logic                        valid;
    logic                        ready;
    logic [cdmr_pkg::WORD_W-1:0] frame_word_zero;
    logic [cdmr_pkg::WORD_W-1:0] frame_word_one;
    logic [cdmr_pkg::WORD_W-1:0] frame_word_two;

    modport source (output valid, output frame_word_zero, output frame_word_one,
                    output frame_word_two, input ready);
    modport sink   (input valid, input frame_word_zero, input frame_word_one,
                    input frame_word_two, output ready);
endinterface

// ===== rtl/core/cdmr_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdmr_cfg_if
// register write channel for the display mode
// ----------------------------------------------------------------------------
interface cdmr_cfg_if;
    logic valid;
    logic ready;
    logic twelve_hour_mode;

    modport source (output valid, output twelve_hour_mode, input ready);
    modport sink   (input valid, input twelve_hour_mode, output ready);
endinterface

// ===== rtl/core/cdmr_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdmr_digits
// display hour rule and decimal split of hour, minute and second
// ----------------------------------------------------------------------------
module cdmr_digits (
    input  logic                          twelve_hour_mode,
    input  logic [cdmr_pkg::HOUR_W-1:0]   hour_value,
    input  logic [cdmr_pkg::MINUTE_W-1:0] minute_value,
    input  logic [cdmr_pkg::SECOND_W-1:0] second_value,
    output cdmr_pkg::digits_t             digits
);

    logic [cdmr_pkg::HOUR_W-1:0] hour_mod;
    logic [cdmr_pkg::HOUR_W-1:0] hour_shown;

    always_comb
    begin
        priority if (hour_value >= 5'd24) hour_mod = hour_value - 5'd24;
        else if (hour_value >= 5'd12)     hour_mod = hour_value - 5'd12;
        else                              hour_mod = hour_value;

        if (twelve_hour_mode)
        begin
            // midnight and noon read as twelve
            hour_shown = (hour_mod == 5'd0) ? 5'd12 : hour_mod;
        end
        else
        begin
            hour_shown = hour_value;
        end
    end

    always_comb
    begin
        digits.hour         = cdmr_pkg::dec_split({1'b0, hour_shown});
        digits.hour_tens_on = (hour_shown >= 5'd10);
        digits.minute       = cdmr_pkg::dec_split(minute_value);
        digits.second       = cdmr_pkg::dec_split(second_value);
    end

endmodule

// ===== rtl/core/cdmr_raster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdmr_raster
// places digit glyphs and second markers into the 12x8 pixel frame
// ----------------------------------------------------------------------------
module cdmr_raster (
    input  cdmr_pkg::digits_t digits,
    output cdmr_pkg::frame_t  frame
);

    // pixel (x,y) sits at bit PIXELS-1-(y*COLS+x), so index 0 is the msb
    function automatic int pix_bit(input int x, input int y);
        return cdmr_pkg::PIXELS - 1 - (y * cdmr_pkg::COLS + x);
    endfunction

    always_comb
    begin
        logic [2:0] ht, hu, mt, mu;
        frame = '0;
        for (int r = 0; r < cdmr_pkg::GLYPH_H; r++)
        begin
            ht = digits.hour_tens_on ?
                 cdmr_pkg::glyph_row({1'b0, digits.hour.tens}, 3'(r)) : 3'b000;
            hu = cdmr_pkg::glyph_row(digits.hour.units, 3'(r));
            mt = cdmr_pkg::glyph_row({1'b0, digits.minute.tens}, 3'(r));
            mu = cdmr_pkg::glyph_row(digits.minute.units, 3'(r));
            for (int c = 0; c < cdmr_pkg::GLYPH_W; c++)
            begin
                frame[pix_bit(cdmr_pkg::HOUR_TENS_X + c, cdmr_pkg::HOUR_Y + r)]  = ht[2-c];
                frame[pix_bit(cdmr_pkg::HOUR_UNITS_X + c, cdmr_pkg::HOUR_Y + r)] = hu[2-c];
                frame[pix_bit(cdmr_pkg::MIN_TENS_X + c, cdmr_pkg::MIN_Y + r)]    = mt[2-c];
                frame[pix_bit(cdmr_pkg::MIN_UNITS_X + c, cdmr_pkg::MIN_Y + r)]   = mu[2-c];
            end
        end
        // second tens of six lands off the right edge and is dropped
        for (int t = 0; t < cdmr_pkg::COLS - cdmr_pkg::SEC_TENS_X; t++)
        begin
            frame[pix_bit(cdmr_pkg::SEC_TENS_X + t, cdmr_pkg::SEC_TENS_Y)] =
                (digits.second.tens == 3'(t));
        end
        for (int u = 0; u < 10; u++)
        begin
            frame[pix_bit(u, cdmr_pkg::SEC_UNITS_Y)] = (digits.second.units == 4'(u));
        end
    end

endmodule

// ===== rtl/core/clock_digit_matrix_renderer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_digit_matrix_renderer_core
// renders hour, minute and second into a 12x8 led frame of three words
// ----------------------------------------------------------------------------
// an accepted time item goes to the input register and then, once the frame
// side is free, to the frame register. throughput: one item per cycle while
// the frame side is ready, set by the input and frame registers; stalls on
// the frame side back up through ready without losing items
// reset clears both valid flags and selects 24-hour display
module clock_digit_matrix_renderer_core (
    input  logic                clk,
    input  logic                rst_n,
    cdmr_time_if.sink           time_item,
    cdmr_frame_if.source        frame,
    cdmr_cfg_if.sink            cfg
);

    logic                          mode_reg;
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [cdmr_pkg::HOUR_W-1:0]   hour_reg;
    logic [cdmr_pkg::MINUTE_W-1:0] minute_reg;
    logic [cdmr_pkg::SECOND_W-1:0] second_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    cdmr_pkg::frame_t              frame_reg;
    cdmr_pkg::frame_t              frame_comb;
    cdmr_pkg::digits_t             digits;
    logic                          advance;
    logic                          take;

    assign advance         = !out_valid_reg || frame.ready;
    assign time_item.ready = !in_valid_reg || advance;
    assign take            = time_item.valid && time_item.ready;
    assign cfg.ready       = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg.valid)
            mode_reg <= cfg.twelve_hour_mode;
    end

    always_comb
    begin
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hour_reg   <= time_item.hour_value;
            minute_reg <= time_item.minute_value;
            second_reg <= time_item.second_value;
        end
        if (advance && in_valid_reg)
            frame_reg <= frame_comb;
    end

    cdmr_digits u_digits (
        .twelve_hour_mode (mode_reg),
        .hour_value       (hour_reg),
        .minute_value     (minute_reg),
        .second_value     (second_reg),
        .digits           (digits)
    );

    cdmr_raster u_raster (
        .digits (digits),
        .frame  (frame_comb)
    );

    assign frame.valid           = out_valid_reg;
    assign frame.frame_word_zero = frame_reg[95:64];
    assign frame.frame_word_one  = frame_reg[63:32];
    assign frame.frame_word_two  = frame_reg[31:0];

    // an item in the input register moves to the frame register when it may
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("item lost between input and frame register");

    // bottom row carries exactly the second units marker
    a_units_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(frame_reg[11:0]))
        else $error("second units row not one-hot");

    // top row carries at most the second tens marker
    a_tens_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(frame_reg[95:84]))
        else $error("second tens row has more than one pixel");

    // left half of the top row is never lit
    a_tens_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (frame_reg[95:90] == 6'b0))
        else $error("pixel lit left of second tens markers");

endmodule
